// ----- design/assert_macros.svh -----
// shared assertion macros for the list engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ple_pkg.sv -----
package ple_pkg;

	localparam int PLE_CAPACITY   = 16;
	localparam int PLE_DATA_WIDTH = 32;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_DEL_FIRST = 3'd2,
		CMD_DEL_LAST  = 3'd3,
		CMD_DEL_POS   = 3'd4,
		CMD_READ      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
	} ple_ctl_t;

endpackage

// ----- design/ple_ctrl.sv -----
module ple_ctrl import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ple_ctl_t ctl
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl.capture = 1'b0;
		ctl.execute = 1'b0;
		// a taken result frees the slot
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// run only once the result slot is free or being emptied
				if (!out_valid_q || out_ready) begin
					ctl.execute = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/ple_datapath.sv -----
module ple_datapath import ple_pkg::*; #(
	parameter int CAPACITY   = PLE_CAPACITY,
	parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ple_ctl_t           ctl,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic [1:0]         status,
	output logic signed [31:0] element_value,
	output logic [4:0]         element_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;

	logic [2:0]                   cmd_q;
	logic signed [31:0]           value_q;
	logic [4:0]                   pos_q;
	logic [CW-1:0]                cnt_q, cnt_d;
	logic signed [DATA_WIDTH-1:0] cells_q [CAPACITY];

	status_t            status_q, stat;
	logic signed [31:0] elem_q, elem;
	logic [4:0]         count_q;

	logic                         full, empty, ins_ok, at_ok;
	logic                         do_ins, do_rem, do_rd;
	logic [IW-1:0]                idx, pos_idx;
	logic [PW-1:0]                pos_ext, cnt_ext;
	logic signed [63:0]           val64, rd64;
	logic signed [DATA_WIDTH-1:0] store, rd_cell;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= command;
			value_q <= value;
			pos_q   <= position;
		end
	end

	assign full    = (cnt_q == CW'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign pos_ext = PW'(pos_q);
	assign cnt_ext = PW'(cnt_q);
	assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1));
	assign at_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign pos_idx = IW'(pos_ext - PW'(1));

	always_comb begin
		stat   = STAT_OK;
		do_ins = 1'b0;
		do_rem = 1'b0;
		do_rd  = 1'b0;
		idx    = '0;
		case (cmd_t'(cmd_q))
			CMD_APPEND: begin
				if (full) stat = STAT_FULL;
				else begin
					do_ins = 1'b1;
					idx    = IW'(cnt_q);
				end
			end
			CMD_INSERT: begin
				if (full) stat = STAT_FULL;
				else if (!ins_ok) stat = STAT_RANGE;
				else begin
					do_ins = 1'b1;
					idx    = pos_idx;
				end
			end
			CMD_DEL_FIRST: begin
				if (empty) stat = STAT_EMPTY;
				else do_rem = 1'b1;
			end
			CMD_DEL_LAST: begin
				if (empty) stat = STAT_EMPTY;
				else begin
					do_rem = 1'b1;
					idx    = IW'(cnt_q - CW'(1));
				end
			end
			CMD_DEL_POS: begin
				if (empty) stat = STAT_EMPTY;
				else if (!at_ok) stat = STAT_RANGE;
				else begin
					do_rem = 1'b1;
					idx    = pos_idx;
				end
			end
			CMD_READ: begin
				if (empty) stat = STAT_EMPTY;
				else if (!at_ok) stat = STAT_RANGE;
				else begin
					do_rd = 1'b1;
					idx   = pos_idx;
				end
			end
			default: begin
				stat = STAT_OK;
			end
		endcase
	end

	// sign-extend the beat value, keep the low data bits
	assign val64   = 64'(value_q);
	assign store   = val64[DATA_WIDTH-1:0];
	assign rd_cell = cells_q[idx];
	assign rd64    = 64'(rd_cell);
	assign elem    = (do_rem || do_rd) ? rd64[31:0] : '0;

	always_comb begin
		cnt_d = cnt_q;
		if (do_ins) cnt_d = cnt_q + CW'(1);
		else if (do_rem) cnt_d = cnt_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.execute) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			status_q <= stat;
			elem_q   <= elem;
			count_q  <= 5'(cnt_d);
		end
	end

	// each cell loads, takes its lower neighbor, takes its upper neighbor or holds
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;
		always_ff @(posedge clk) begin
			if (ctl.execute) begin
				if (do_ins) begin
					if (IW'(i) == idx) cells_q[i] <= store;
					else if (IW'(i) > idx) cells_q[i] <= cells_q[PREV];
				end else if (do_rem && (IW'(i) >= idx)) begin
					cells_q[i] <= cells_q[NEXT];
				end
			end
		end
	end

	assign status        = status_q;
	assign element_value = elem_q;
	assign element_count = count_q;

endmodule

// ----- design/positional_list_engine.sv -----
// channel | signals                                   | dir
// --------+-------------------------------------------+-----
// in      | in_valid, in_ready, command, value,        | in
//         | position                                  |
// out     | out_valid, out_ready, status,              | out
//         | element_value, element_count              |
//
// each command first registers its beat; then the cell
// row shifts, loads or holds and the result register loads
// the next command is taken while a result still waits in the result register
// a stalled output holds the command in its execute cycle until the slot frees
// reset clears the count and the handshake state; cell contents are left as is
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY   = PLE_CAPACITY,
	parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] element_value,
	output logic [4:0]         element_count
);

	ple_ctl_t ctl;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	ple_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.command       (command),
		.value         (value),
		.position      (position),
		.status        (status),
		.element_value (element_value),
		.element_count (element_count)
	);

endmodule

// ----- design/ple_checker.sv -----
`include "assert_macros.svh"

module ple_checker import ple_pkg::*; #(
	parameter int CAPACITY = PLE_CAPACITY
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic signed [31:0] element_value,
	input logic [4:0]         element_count
);

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(element_value) && $stable(element_count), "stalled result beat changed")
	`ASSERT_NOW(a_full_count, out_valid && (status == STAT_FULL), element_count == 5'(CAPACITY) && element_value == '0, "full refusal without a full count")
	`ASSERT_NOW(a_empty_count, out_valid && (status == STAT_EMPTY), element_count == '0 && element_value == '0, "empty refusal with elements left")
	`ASSERT_NOW(a_range_zero, out_valid && (status == STAT_RANGE), element_value == '0, "range refusal carries a value")
	`ASSERT_NOW(a_count_cap, out_valid, 32'(element_count) <= CAPACITY, "count above capacity")

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.element_value (element_value),
	.element_count (element_count)
);

// ----- verif/positional_list_engine_tb.sv -----
module positional_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int CAPACITY = PLE_CAPACITY;
	localparam int QUIET_LIMIT = 500;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PLAN_ROWS = 26;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] elem;
		logic [4:0]         count;
	} list_reply_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] val;
		logic [4:0]         pos;
		logic [4:0]         reps;
		bit                 rand_val;
		bit                 typed;
		list_reply_t        reply;
	} plan_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         command = CMD_APPEND;
	logic signed [31:0] value = '0;
	logic [4:0]         position = 5'd1;
	logic               out_valid;
	logic               out_ready = 1'b1;
	logic [1:0]         status;
	logic signed [31:0] element_value;
	logic [4:0]         element_count;

	// shadow copy of the list, kept in step with accepted commands
	logic signed [31:0] shadow_cells [CAPACITY];
	int                 shadow_count = 0;

	list_reply_t awaited_replies [$];
	plan_row_t   plan [PLAN_ROWS];

	int mismatches = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int status_hits [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	positional_list_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.element_value(element_value),
		.element_count(element_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void put_in(input int idx, input logic signed [31:0] val);
		for (int i = shadow_count; i > idx; i--)
			shadow_cells[i] = shadow_cells[i - 1];
		shadow_cells[idx] = val;
		shadow_count++;
	endfunction

	function automatic logic signed [31:0] take_out(input int idx);
		logic signed [31:0] v;
		v = shadow_cells[idx];
		for (int i = idx; i + 1 < shadow_count; i++)
			shadow_cells[i] = shadow_cells[i + 1];
		shadow_count--;
		return v;
	endfunction

	function automatic list_reply_t apply_command(input logic [2:0] cmd,
			input logic signed [31:0] val, input logic [4:0] pos);
		list_reply_t r;
		int p;
		p = int'(pos);
		r.status = STAT_OK;
		r.elem = '0;
		case (cmd)
			CMD_APPEND: begin
				if (shadow_count >= CAPACITY) r.status = STAT_FULL;
				else put_in(shadow_count, val);
			end
			CMD_INSERT: begin
				if (shadow_count >= CAPACITY) r.status = STAT_FULL;
				else if (p < 1 || p > shadow_count + 1) r.status = STAT_RANGE;
				else put_in(p - 1, val);
			end
			CMD_DEL_FIRST: begin
				if (shadow_count == 0) r.status = STAT_EMPTY;
				else r.elem = take_out(0);
			end
			CMD_DEL_LAST: begin
				if (shadow_count == 0) r.status = STAT_EMPTY;
				else r.elem = take_out(shadow_count - 1);
			end
			CMD_DEL_POS: begin
				if (shadow_count == 0) r.status = STAT_EMPTY;
				else if (p < 1 || p > shadow_count) r.status = STAT_RANGE;
				else r.elem = take_out(p - 1);
			end
			CMD_READ: begin
				if (shadow_count == 0) r.status = STAT_EMPTY;
				else if (p < 1 || p > shadow_count) r.status = STAT_RANGE;
				else r.elem = shadow_cells[p - 1];
			end
			default: ;
		endcase
		r.count = shadow_count[4:0];
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sh0000_0000;
			3: return 32'shffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// hold one command beat until taken, then log what it should produce
	task automatic push_command(input logic [2:0] cmd, input logic signed [31:0] val,
			input logic [4:0] pos, input bit typed, input list_reply_t typed_reply);
		list_reply_t predicted;
		in_valid <= 1'b1;
		command <= cmd;
		value <= val;
		position <= pos;
		do @(posedge clk); while (!(in_valid && in_ready));
		predicted = apply_command(cmd, val, pos);
		awaited_replies.push_back(typed ? typed_reply : predicted);
		beats_sent++;
		if ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// result side: compare every taken beat with the oldest expectation
	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: result beat with nothing outstanding (status %0d)",
						status);
			end else begin
				want = awaited_replies.pop_front();
				status_hits[want.status]++;
				if (status !== want.status || element_value !== want.elem ||
						element_count !== want.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected status %0d value %h count %0d, ",
							"got status %0d value %h count %0d"},
							want.status, want.elem, want.count,
							status, element_value, element_count);
				end
			end
		end
	end

	// random backpressure bursts on the result side
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && $urandom_range(0, 99) < out_stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		plan_row_t   row;
		list_reply_t none;
		logic [2:0]  cmd;
		logic [4:0]  pos;
		int          r;
		int          hi;
		int          target;
		bit          grow;

		none = '0;
		plan = '{
			'{CMD_READ, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1, '{STAT_EMPTY, 32'sd0, 5'd0}},
			'{CMD_DEL_FIRST, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1, '{STAT_EMPTY, 32'sd0, 5'd0}},
			'{CMD_DEL_LAST, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1, '{STAT_EMPTY, 32'sd0, 5'd0}},
			'{CMD_DEL_POS, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1, '{STAT_EMPTY, 32'sd0, 5'd0}},
			// empty wins over a bad position
			'{CMD_READ, 32'sd0, 5'd17, 5'd1, 1'b0, 1'b1, '{STAT_EMPTY, 32'sd0, 5'd0}},
			'{CMD_INSERT, 32'sd5, 5'd2, 5'd1, 1'b0, 1'b1, '{STAT_RANGE, 32'sd0, 5'd0}},
			'{CMD_INSERT, 32'sh8000_0000, 5'd1, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sd0, 5'd1}},
			'{CMD_APPEND, 32'sh7fff_ffff, 5'd1, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sd0, 5'd2}},
			'{CMD_READ, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sh8000_0000, 5'd2}},
			'{CMD_READ, 32'sd0, 5'd3, 5'd1, 1'b0, 1'b1, '{STAT_RANGE, 32'sd0, 5'd2}},
			'{CMD_DEL_POS, 32'sd0, 5'd3, 5'd1, 1'b0, 1'b1, '{STAT_RANGE, 32'sd0, 5'd2}},
			'{CMD_SPARE_6, 32'sh1234_5678, 5'd1, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sd0, 5'd2}},
			'{CMD_SPARE_7, 32'shffff_ffff, 5'd17, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sd0, 5'd2}},
			// insert one past the end acts as append
			'{CMD_INSERT, 32'shffff_ffff, 5'd3, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sd0, 5'd3}},
			'{CMD_DEL_POS, 32'sd0, 5'd2, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sh7fff_ffff, 5'd2}},
			'{CMD_DEL_FIRST, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'sh8000_0000, 5'd1}},
			// removing the only element
			'{CMD_DEL_LAST, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1,
				'{STAT_OK, 32'shffff_ffff, 5'd0}},
			'{CMD_APPEND, 32'sd0, 5'd1, 5'd16, 1'b1, 1'b0, '0},
			'{CMD_APPEND, 32'sd0, 5'd1, 5'd1, 1'b0, 1'b1, '{STAT_FULL, 32'sd0, 5'd16}},
			// full wins over a bad position
			'{CMD_INSERT, 32'sd0, 5'd17, 5'd1, 1'b0, 1'b1, '{STAT_FULL, 32'sd0, 5'd16}},
			'{CMD_READ, 32'sd0, 5'd17, 5'd1, 1'b0, 1'b1, '{STAT_RANGE, 32'sd0, 5'd16}},
			'{CMD_READ, 32'sd0, 5'd16, 5'd1, 1'b0, 1'b0, '0},
			'{CMD_DEL_POS, 32'sd0, 5'd16, 5'd1, 1'b0, 1'b0, '0},
			'{CMD_INSERT, 32'sd0, 5'd17, 5'd1, 1'b0, 1'b1, '{STAT_RANGE, 32'sd0, 5'd15}},
			'{CMD_INSERT, 32'sd0, 5'd16, 5'd1, 1'b1, 1'b0, '0},
			'{CMD_DEL_POS, 32'sd0, 5'd1, 5'd16, 1'b0, 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 10;
		out_stall_pct = 4;
		foreach (plan[k]) begin
			row = plan[k];
			for (int j = 0; j < int'(row.reps); j++)
				push_command(row.cmd, row.rand_val ? pick_value() : row.val, row.pos,
					row.typed, row.reply);
		end

		target = CAPACITY;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i)
				0:    begin in_idle_pct = 12; out_stall_pct = 5;  end
				500:  begin in_idle_pct = 35; out_stall_pct = 12; end
				900:  begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1100: begin in_idle_pct = 20; out_stall_pct = 8;  end
				1300: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				default: ;
			endcase
			// hold off until the result side has caught up
			if (i == 450) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (awaited_replies.size() != 0);
			end
			// steer the fill level between empty, full and in between
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: target = 0;
					1: target = CAPACITY;
					default: target = $urandom_range(0, CAPACITY);
				endcase
			end
			if (target == CAPACITY) grow = 1'b1;
			else if (target == 0) grow = 1'b0;
			else grow = shadow_count < target;

			r = $urandom_range(0, 99);
			if (r < 2) cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
			else if (r < 16) cmd = CMD_READ;
			else if (r < (grow ? 46 : 28)) cmd = CMD_APPEND;
			else if (r < (grow ? 76 : 40)) cmd = CMD_INSERT;
			else if (r < (grow ? 84 : 60)) cmd = CMD_DEL_FIRST;
			else if (r < (grow ? 92 : 80)) cmd = CMD_DEL_LAST;
			else cmd = CMD_DEL_POS;

			hi = (cmd == CMD_INSERT) ? shadow_count + 1 : shadow_count;
			if (hi < 1) hi = 1;
			if ($urandom_range(0, 99) < 85) pos = 5'($urandom_range(1, hi));
			else pos = 5'($urandom_range(1, 17));

			push_command(cmd, pick_value(), pos, 1'b0, none);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_replies.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += awaited_replies.size();

		$display("covered %0d commands, %0d results: ok %0d, full %0d, empty %0d, bad position %0d",
			beats_sent, results_seen, status_hits[STAT_OK], status_hits[STAT_FULL],
			status_hits[STAT_EMPTY], status_hits[STAT_RANGE]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/ple_pkg.sv
design/ple_ctrl.sv
design/ple_datapath.sv
design/positional_list_engine.sv
design/ple_checker.sv
verif/positional_list_engine_tb.sv
